// ===== sv/mpool_pkg.sv =====
// Shared types and constants for the 2x2 stride-2 mean pooling block.
`default_nettype none
package mpool_pkg;

  localparam int CFG_DATA_BITS     = 13;
  localparam int MAX_SOURCE_HEIGHT = 4096;

  // Configuration register file contents
  typedef struct packed {
    logic [12:0] source_height;
    logic [11:0] source_width;
    logic        pad_rows;
    logic        pad_cols;
    logic [11:0] out_height;
    logic [10:0] out_width;
    logic        include_padding;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_SOURCE_HEIGHT   = 3'd0,
    REG_SOURCE_WIDTH    = 3'd1,
    REG_PAD_ROWS        = 3'd2,
    REG_PAD_COLS        = 3'd3,
    REG_OUT_HEIGHT      = 3'd4,
    REG_OUT_WIDTH       = 3'd5,
    REG_INCLUDE_PADDING = 3'd6
  } reg_index_t;

  // Window control carried from the front stage to the output register
  typedef struct packed {
    logic       emit;
    logic       use_top;
    logic [2:0] real_count;
    logic [1:0] shift;
    logic       row_end;
    logic       frame_end;
  } win_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/mean_pool_2x2_stride2_padded_core.sv =====
// Front register loads at the sample's transaction; the output register loads from it when take is high.
// Throughput: one sample per cycle unless out_stall holds; pair store: one write and one read port per cycle.
// Output stall backs up into the input within the same cycle only when both stages are full.
// Reset (rst, synchronous): config returns to 2, 2, 0, 0, 1, 1, 1; raster position and valids clear.
// The pair store is not cleared; a write to a defined config register restarts the frame at the first sample.
`default_nettype none
module mean_pool_2x2_stride2_padded_core #(
  parameter int MAX_SOURCE_WIDTH = 2048,
  parameter int SAMPLE_BITS      = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [2:0]                            cfg_index,
  input  wire logic [mpool_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [SAMPLE_BITS-1:0]                sample_value,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [SAMPLE_BITS-1:0]                     pooled_value,
  output logic [2:0]                                 real_count,
  output logic                                       row_end,
  output logic                                       frame_end
);
  import mpool_pkg::*;

  cfg_t                     cfg;
  cfg_t                     cfg_next;
  logic                     cfg_hit;
  logic                     take;
  logic                     a_valid;
  win_ctrl_t                a_ctrl;
  logic signed [SAMPLE_BITS:0] a_sum;
  logic signed [SAMPLE_BITS:0] a_top;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_next = cfg;
    cfg_hit  = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_SOURCE_HEIGHT: begin
          cfg_next.source_height = cfg_data[12:0];
          cfg_hit = 1'b1;
        end
        REG_SOURCE_WIDTH: begin
          cfg_next.source_width = cfg_data[11:0];
          cfg_hit = 1'b1;
        end
        REG_PAD_ROWS: begin
          cfg_next.pad_rows = cfg_data[0];
          cfg_hit = 1'b1;
        end
        REG_PAD_COLS: begin
          cfg_next.pad_cols = cfg_data[0];
          cfg_hit = 1'b1;
        end
        REG_OUT_HEIGHT: begin
          cfg_next.out_height = cfg_data[11:0];
          cfg_hit = 1'b1;
        end
        REG_OUT_WIDTH: begin
          cfg_next.out_width = cfg_data[10:0];
          cfg_hit = 1'b1;
        end
        REG_INCLUDE_PADDING: begin
          cfg_next.include_padding = cfg_data[0];
          cfg_hit = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_height   <= 13'd2;
      cfg.source_width    <= 12'd2;
      cfg.pad_rows        <= 1'b0;
      cfg.pad_cols        <= 1'b0;
      cfg.out_height      <= 12'd1;
      cfg.out_width       <= 11'd1;
      cfg.include_padding <= 1'b1;
    end else begin
      cfg <= cfg_next;
    end
  end

  mpool_front #(
    .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .restart      (cfg_hit),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_value (sample_value),
    .take         (take),
    .a_valid      (a_valid),
    .a_ctrl       (a_ctrl),
    .a_sum        (a_sum),
    .a_top        (a_top)
  );

  mpool_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .a_valid      (a_valid),
    .a_ctrl       (a_ctrl),
    .a_sum        (a_sum),
    .a_top        (a_top),
    .take         (take),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pooled_value (pooled_value),
    .real_count   (real_count),
    .row_end      (row_end),
    .frame_end    (frame_end)
  );

endmodule
`default_nettype wire

// ===== sv/mpool_front.sv =====
// Front stage: raster position tracking, horizontal pair sums, pair store, window control.
`default_nettype none
module mpool_front #(
  parameter int MAX_SOURCE_WIDTH = 2048,
  parameter int SAMPLE_BITS      = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mpool_pkg::cfg_t               cfg,
  input  wire logic                          restart,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [SAMPLE_BITS-1:0]        sample_value,
  input  wire logic                          take,
  output logic                               a_valid,
  output mpool_pkg::win_ctrl_t               a_ctrl,
  output logic signed [SAMPLE_BITS:0]        a_sum,
  output logic signed [SAMPLE_BITS:0]        a_top
);
  import mpool_pkg::*;

  localparam int WB         = $clog2(MAX_SOURCE_WIDTH + 1);
  localparam int CB         = (MAX_SOURCE_WIDTH > 2) ? $clog2(MAX_SOURCE_WIDTH) : 1;
  localparam int AW         = WB - 1;
  localparam int PAIR_DEPTH = MAX_SOURCE_WIDTH / 2 + 1;
  localparam int SW         = (WB > 12) ? WB : 12;
  localparam int XW         = (AW > 11) ? AW : 11;
  localparam int HW         = SAMPLE_BITS + 1;

  logic signed [HW-1:0] pair_sums [PAIR_DEPTH];
  logic signed [HW-1:0] hpart;
  logic [CB-1:0]        col;
  logic [11:0]          row;
  logic [CB-1:0]        col_next;
  logic [11:0]          row_next;

  logic [SW-1:0]        sw_ext;
  logic [WB-1:0]        wid;
  logic [12:0]          hgt;
  logic [WB-1:0]        pc;
  logic [12:0]          pr;
  logic [AW-1:0]        ox;
  logic [11:0]          oy;
  logic                 col_odd, row_odd, col_first, row_first;
  logic                 hlast, vlast, cols2, rows2;
  logic signed [HW-1:0] s_ext;
  logic signed [HW-1:0] h;
  logic                 accept;
  logic                 wr_en;
  logic [WB-1:0]        lox_full;
  logic [AW-1:0]        last_ox;
  logic [XW-1:0]        ow_m1;
  logic [XW-1:0]        end_ox;
  logic [12:0]          loy_full;
  logic [11:0]          last_oy;
  logic [11:0]          oh_m1;
  logic [11:0]          end_oy;
  logic [WB-1:0]        col_inc;
  logic [12:0]          row_inc;
  win_ctrl_t            ctrl;

  // effective image size
  always_comb begin
    sw_ext = SW'(cfg.source_width);
    if (sw_ext == '0) begin
      wid = WB'(1);
    end else if (sw_ext > SW'(MAX_SOURCE_WIDTH)) begin
      wid = WB'(MAX_SOURCE_WIDTH);
    end else begin
      wid = sw_ext[WB-1:0];
    end
    if (cfg.source_height == '0) begin
      hgt = 13'd1;
    end else if (cfg.source_height > 13'(MAX_SOURCE_HEIGHT)) begin
      hgt = 13'(MAX_SOURCE_HEIGHT);
    end else begin
      hgt = cfg.source_height;
    end
  end

  assign pc        = WB'(col) + WB'(cfg.pad_cols);
  assign pr        = 13'(row) + 13'(cfg.pad_rows);
  assign ox        = pc[WB-1:1];
  assign oy        = pr[12:1];
  assign col_odd   = pc[0];
  assign row_odd   = pr[0];
  assign col_first = (col == '0);
  assign row_first = (row == '0);
  assign hlast     = col_odd || (WB'(col) == wid - WB'(1));
  assign vlast     = row_odd || (13'(row) == hgt - 13'd1);
  assign cols2     = col_odd && !col_first;
  assign rows2     = row_odd && !row_first;

  assign s_ext = HW'(signed'(sample_value));
  assign h     = (!col_odd || col_first) ? s_ext : hpart + s_ext;

  // last output column/row that the image reaches, clipped by the output limits
  always_comb begin
    lox_full = wid - WB'(1) + WB'(cfg.pad_cols);
    last_ox  = lox_full[WB-1:1];
    ow_m1    = XW'(cfg.out_width) - XW'(1);
    if (cfg.out_width == '0 || ow_m1 >= XW'(last_ox)) begin
      end_ox = XW'(last_ox);
    end else begin
      end_ox = ow_m1;
    end
    loy_full = hgt - 13'd1 + 13'(cfg.pad_rows);
    last_oy  = loy_full[12:1];
    oh_m1    = cfg.out_height - 12'd1;
    if (cfg.out_height == '0 || oh_m1 >= last_oy) begin
      end_oy = last_oy;
    end else begin
      end_oy = oh_m1;
    end
  end

  always_comb begin
    ctrl.emit      = hlast && vlast && (XW'(ox) < XW'(cfg.out_width)) &&
                     (oy < cfg.out_height);
    ctrl.use_top   = rows2;
    if (rows2 && cols2) begin
      ctrl.real_count = 3'd4;
    end else if (rows2 || cols2) begin
      ctrl.real_count = 3'd2;
    end else begin
      ctrl.real_count = 3'd1;
    end
    if (cfg.include_padding || (rows2 && cols2)) begin
      ctrl.shift = 2'd2;
    end else if (rows2 || cols2) begin
      ctrl.shift = 2'd1;
    end else begin
      ctrl.shift = 2'd0;
    end
    ctrl.row_end   = (XW'(ox) == end_ox);
    ctrl.frame_end = ctrl.row_end && (oy == end_oy);
  end

  assign in_stall = a_valid && !take;
  assign accept   = in_valid && !in_stall;
  assign wr_en    = accept && hlast && !vlast;

  // raster counters
  always_comb begin
    col_inc = WB'(col) + WB'(1);
    row_inc = 13'(row) + 13'd1;
    if (col_inc >= wid) begin
      col_next = '0;
      if (row_inc >= hgt) begin
        row_next = '0;
      end else begin
        row_next = row_inc[11:0];
      end
    end else begin
      col_next = col_inc[CB-1:0];
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hpart   <= '0;
      a_valid <= 1'b0;
    end else begin
      if (accept) begin
        hpart <= h;
      end
      if (accept) begin
        a_valid <= 1'b1;
      end else if (take) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_ctrl <= ctrl;
      a_sum  <= h;
    end
  end

  // pair store: upper-row pair sums, read one row later at the same output column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pair_sums[ox] <= h;
    end
    if (accept) begin
      a_top <= pair_sums[ox];
    end
  end

endmodule
`default_nettype wire

// ===== sv/mpool_back.sv =====
// Output register: window total, floor shift and result handshake.
`default_nettype none
module mpool_back #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          a_valid,
  input  wire mpool_pkg::win_ctrl_t          a_ctrl,
  input  wire logic signed [SAMPLE_BITS:0]   a_sum,
  input  wire logic signed [SAMPLE_BITS:0]   a_top,
  output logic                               take,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [SAMPLE_BITS-1:0]             pooled_value,
  output logic [2:0]                         real_count,
  output logic                               row_end,
  output logic                               frame_end
);
  import mpool_pkg::*;

  localparam int TW = SAMPLE_BITS + 2;

  logic signed [TW-1:0] top_ext;
  logic signed [TW-1:0] total;
  logic signed [TW-1:0] mean;

  assign take    = !out_valid || !out_stall;
  assign top_ext = a_ctrl.use_top ? TW'(a_top) : '0;
  assign total   = top_ext + TW'(a_sum);

  // arithmetic shift rounds toward minus infinity
  always_comb begin
    case (a_ctrl.shift)
      2'd0:    mean = total;
      2'd1:    mean = total >>> 1;
      default: mean = total >>> 2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= a_valid && a_ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take && a_valid) begin
      pooled_value <= mean[SAMPLE_BITS-1:0];
      real_count   <= a_ctrl.real_count;
      row_end      <= a_ctrl.row_end;
      frame_end    <= a_ctrl.frame_end;
    end
  end

endmodule
`default_nettype wire

// ===== tb/pool_window_checker.sv =====
// Checker for the mean pool core: predicts every pooled window and compares the output stream.
`timescale 1ns / 1ps
module pool_window_checker #(
  parameter int MAX_SOURCE_WIDTH = 2048,
  parameter int SAMPLE_BITS      = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  input  wire logic                                cfg_ready,
  input  wire logic [2:0]                          cfg_index,
  input  wire logic [mpool_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  wire logic                                in_valid,
  input  wire logic                                in_stall,
  input  wire logic [SAMPLE_BITS-1:0]              sample_value,
  input  wire logic                                out_valid,
  input  wire logic                                out_stall,
  input  wire logic [SAMPLE_BITS-1:0]              pooled_value,
  input  wire logic [2:0]                          real_count,
  input  wire logic                                row_end,
  input  wire logic                                frame_end,
  output int                                       errors,
  output int                                       pending
);
  import mpool_pkg::*;

  localparam int PAIR_DEPTH = MAX_SOURCE_WIDTH / 2 + 1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] value;
    logic [2:0]             count;
    logic                   row_last;
    logic                   frame_last;
  } window_t;

  cfg_t    shape;
  int      pair_sum_row [PAIR_DEPTH];
  int      row_sum;
  int      row_pos;
  int      col_pos;
  window_t window_q [$];
  window_t got_w;
  window_t want_w;
  int      mismatches = 0;
  bit      restart;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic int active_height();
    int h;
    h = int'(shape.source_height);
    if (h == 0) return 1;
    return (h > MAX_SOURCE_HEIGHT) ? MAX_SOURCE_HEIGHT : h;
  endfunction

  function automatic int active_width();
    int w;
    w = int'(shape.source_width);
    if (w == 0) return 1;
    return (w > MAX_SOURCE_WIDTH) ? MAX_SOURCE_WIDTH : w;
  endfunction

  // One accepted sample: update line store and running sums, queue the window it closes
  task automatic predict_window(input logic [SAMPLE_BITS-1:0] smp);
    int      hgt, wid, pr, pc, oy, ox, s, h, top, total, cnt, k;
    int      last_ox, last_oy, end_ox, end_oy;
    bit      col_odd, row_odd, hlast, vlast;
    window_t w;
    hgt     = active_height();
    wid     = active_width();
    pr      = row_pos + int'(shape.pad_rows);
    pc      = col_pos + int'(shape.pad_cols);
    oy      = pr >> 1;
    ox      = pc >> 1;
    col_odd = pc[0];
    row_odd = pr[0];
    hlast   = col_odd || col_pos == wid - 1;
    vlast   = row_odd || row_pos == hgt - 1;
    s       = $signed(smp);
    h       = (!col_odd || col_pos == 0) ? s : row_sum + s;
    row_sum = h;

    if (hlast) begin
      if (vlast) begin
        cnt   = ((col_odd && col_pos > 0) ? 2 : 1) * ((row_odd && row_pos > 0) ? 2 : 1);
        top   = (row_odd && row_pos > 0 && ox < PAIR_DEPTH) ? pair_sum_row[ox] : 0;
        total = top + h;
        if (oy < int'(shape.out_height) && ox < int'(shape.out_width)) begin
          k       = shape.include_padding ? 2 : (cnt == 4 ? 2 : (cnt == 2 ? 1 : 0));
          last_ox = (wid - 1 + int'(shape.pad_cols)) >> 1;
          last_oy = (hgt - 1 + int'(shape.pad_rows)) >> 1;
          end_ox  = (int'(shape.out_width) - 1 < last_ox) ? int'(shape.out_width) - 1 : last_ox;
          end_oy  = (int'(shape.out_height) - 1 < last_oy) ? int'(shape.out_height) - 1 : last_oy;
          w.value      = SAMPLE_BITS'(total >>> k);
          w.count      = 3'(cnt);
          w.row_last   = (ox == end_ox);
          w.frame_last = w.row_last && (oy == end_oy);
          window_q.push_back(w);
        end
      end else if (ox < PAIR_DEPTH) begin
        pair_sum_row[ox] = h;
      end
    end

    col_pos++;
    if (col_pos >= wid) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= hgt) row_pos = 0;
    end
  endtask

  task automatic compare_field(input string field, input logic signed [31:0] want_v,
                               input logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      if (mismatches < 40)
        $display("%0t ns: %s expected %0d actual %0d", $time, field, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      shape.source_height   = 13'd2;
      shape.source_width    = 12'd2;
      shape.pad_rows        = 1'b0;
      shape.pad_cols        = 1'b0;
      shape.out_height      = 12'd1;
      shape.out_width       = 11'd1;
      shape.include_padding = 1'b1;
      row_sum = 0;
      row_pos = 0;
      col_pos = 0;
      window_q.delete();
    end else begin
      // a result leaving now is checked before any new sample is predicted
      if (out_valid && !out_stall) begin
        got_w = '{pooled_value, real_count, row_end, frame_end};
        if (window_q.size() == 0) begin
          if (mismatches < 40)
            $display("%0t ns: unexpected result, expected none actual %0d", $time,
                     $signed(pooled_value));
          mismatches++;
        end else begin
          want_w = window_q.pop_front();
          compare_field("pooled_value", $signed(want_w.value), $signed(got_w.value));
          compare_field("real_count", want_w.count, got_w.count);
          compare_field("row_end", want_w.row_last, got_w.row_last);
          compare_field("frame_end", want_w.frame_last, got_w.frame_last);
        end
      end

      if (cfg_valid && cfg_ready) begin
        restart = 1'b1;
        case (cfg_index)
          REG_SOURCE_HEIGHT:   shape.source_height   = cfg_data[12:0];
          REG_SOURCE_WIDTH:    shape.source_width    = cfg_data[11:0];
          REG_PAD_ROWS:        shape.pad_rows        = cfg_data[0];
          REG_PAD_COLS:        shape.pad_cols        = cfg_data[0];
          REG_OUT_HEIGHT:      shape.out_height      = cfg_data[11:0];
          REG_OUT_WIDTH:       shape.out_width       = cfg_data[10:0];
          REG_INCLUDE_PADDING: shape.include_padding = cfg_data[0];
          default:             restart = 1'b0;
        endcase
        if (restart) begin
          row_pos = 0;
          col_pos = 0;
        end
      end

      if (in_valid && !in_stall) predict_window(sample_value);
    end
    pending <= window_q.size();
    errors  <= mismatches;
  end

endmodule

// ===== tb/tb_mean_pool_2x2_stride2_padded_core.sv =====
// Top-level testbench for the 2x2 stride-2 mean pool core: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_mean_pool_2x2_stride2_padded_core;
  import mpool_pkg::*;

  localparam int         SAMPLE_BITS  = 16;
  localparam int         RANDOM_ITEMS = 300;
  localparam int         QUIET_LIMIT  = 2000;
  localparam logic [2:0] REG_UNUSED   = 3'd7;
  localparam logic [15:0] MOST_POS    = 16'h7fff;
  localparam logic [15:0] MOST_NEG    = 16'h8000;

  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     cfg_valid    = 1'b0;
  logic                     cfg_ready;
  logic [2:0]               cfg_index    = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data     = '0;
  logic                     in_valid     = 1'b0;
  logic                     in_stall;
  logic [SAMPLE_BITS-1:0]   sample_value = '0;
  logic                     out_valid;
  logic                     out_stall    = 1'b0;
  logic [SAMPLE_BITS-1:0]   pooled_value;
  logic [2:0]               real_count;
  logic                     row_end;
  logic                     frame_end;
  int                       errors;
  int                       pending;
  int                       idle_pct     = 38;
  int                       stall_pct    = 38;
  int                       quiet_cycles = 0;

  mean_pool_2x2_stride2_padded_core u_top (.*);

  pool_window_checker u_checker (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) out_stall <= !rst && ($urandom_range(0, 99) < stall_pct);

  // no transaction on any channel for too long means the block hung
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [2:0] idx, input int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_BITS'(data);
    do @(posedge clk); while (!cfg_ready);
  endtask

  // dirty sets the bits above each field but the source height, which the register must drop
  task automatic load_shape(input int h, input int w, input int pr, input int pc,
                            input int oh, input int ow, input int inc, input bit dirty);
    write_reg(REG_SOURCE_HEIGHT, h);
    write_reg(REG_SOURCE_WIDTH, w | (dirty ? ($urandom << 12) : 0));
    write_reg(REG_PAD_ROWS, pr | (dirty ? ($urandom << 1) : 0));
    write_reg(REG_PAD_COLS, pc | (dirty ? ($urandom << 1) : 0));
    write_reg(REG_OUT_HEIGHT, oh | (dirty ? ($urandom << 12) : 0));
    write_reg(REG_OUT_WIDTH, ow | (dirty ? ($urandom << 11) : 0));
    write_reg(REG_INCLUDE_PADDING, inc | (dirty ? ($urandom << 1) : 0));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample_value <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending, let every queued window come out, then let the pipeline empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return MOST_POS;
      1:       return MOST_NEG;
      2:       return '1;
      3:       return '0;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  initial begin
    int                     h, w, pr, pc, oh, ow, inc, n, fed, phase;
    bit                     paused;
    logic [SAMPLE_BITS-1:0] corner [9];
    corner = '{MOST_POS, MOST_NEG, 16'hffff, 16'h0001, MOST_NEG, MOST_NEG, 16'hffff,
               16'h0000, MOST_POS};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset shape: two frames of one 2x2 window, extreme sums both ways
    repeat (4) send_sample(MOST_POS);
    repeat (4) send_sample(MOST_NEG);
    drain();

    // padded 3x3 in exclude mode: windows of 1, 2 and 4 real samples, floor rounding
    load_shape(3, 3, 1, 1, 2, 2, 0, 1'b0);
    foreach (corner[i]) send_sample(corner[i]);
    drain();

    // include mode still divides border windows by four
    load_shape(2, 3, 1, 1, 2, 2, 1, 1'b0);
    for (int i = 0; i < 6; i++) send_sample(corner[i]);
    drain();

    // zero source size acts as one sample; two frames back to back
    load_shape(0, 0, 1, 1, 1, 1, 0, 1'b0);
    send_sample(MOST_NEG);
    send_sample(MOST_POS);
    drain();

    // zero output size suppresses everything
    load_shape(2, 2, 0, 0, 0, 0, 1, 1'b0);
    repeat (4) send_sample(pick_sample());
    drain();

    // full line store width with padding on both sides; start of the frame only
    load_shape(3, 2048, 1, 1, 2, 1025, 0, 1'b0);
    repeat (48) send_sample(pick_sample());
    drain();

    // oversize width acts as the line store capacity; start of the frame only
    load_shape(1, 4095, 0, 1, 1, 2047, 1, 1'b0);
    repeat (32) send_sample(pick_sample());
    drain();

    // oversize height, no idling on either side
    idle_pct  = 0;
    stall_pct = 0;
    load_shape(8191, 1, 1, 0, 4095, 1, 0, 1'b0);
    repeat (32) send_sample(pick_sample());
    drain();

    fed    = 0;
    phase  = 0;
    paused = 1'b0;
    while (fed < RANDOM_ITEMS) begin
      if (phase % 6 == 3) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = 38;
        stall_pct = 38;
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg(REG_UNUSED, $urandom);
        cfg_valid <= 1'b0;
        @(posedge clk);
      end
      h   = $urandom_range(0, 7);
      w   = $urandom_range(0, 9);
      pr  = $urandom_range(0, 1);
      pc  = $urandom_range(0, 1);
      inc = $urandom_range(0, 1);
      case ($urandom_range(0, 9))
        0:       oh = 0;
        1:       oh = 4095;
        2:       oh = 1;
        default: oh = $urandom_range(1, 5);
      endcase
      case ($urandom_range(0, 9))
        0:       ow = 0;
        1:       ow = 2047;
        2:       ow = 1;
        default: ow = $urandom_range(1, 6);
      endcase
      load_shape(h, w, pr, pc, oh, ow, inc, $urandom_range(0, 3) == 0);
      n = (h == 0 ? 1 : h) * (w == 0 ? 1 : w) * $urandom_range(1, 2);
      // now and then a frame cut short by the next configuration
      if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
      for (int i = 0; i < n; i++) begin
        if (i == n / 2 && (!paused || $urandom_range(0, 9) == 0)) begin
          drain();
          paused = 1'b1;
        end
        send_sample(pick_sample());
        fed++;
      end
      drain();
      phase++;
    end

    repeat (6) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
